// ===== rtl/sed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg: shared definitions of the Sobel edge detector
// Field widths, register indexes and reset values, window and result types,
// and the gradient magnitude of one 3x3 window.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int SED_MAX_WIDTH = 1024;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int THR_W      = 11;
    localparam int EV_W       = 8;
    localparam int MAG_W      = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int RES_MAX      = 4;
    localparam int RES_IDX_W    = 2;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_VALUE   = CFG_IDX_W'(3);

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = FH_W'(480);
    localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(128);
    localparam logic [EV_W-1:0]  EDGE_VALUE_RST   = EV_W'(1);

    // window rows and columns
    localparam logic [1:0] ROW_UP  = 2'd0;
    localparam logic [1:0] ROW_MID = 2'd1;
    localparam logic [1:0] ROW_DN  = 2'd2;
    localparam logic [1:0] COL_L   = 2'd0;
    localparam logic [1:0] COL_C   = 2'd1;
    localparam logic [1:0] COL_R   = 2'd2;

    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic c_eq0;
        logic c_eq1;
        logic r_eq0;
        logic r_eq1;
        logic emit_a;
        logic emit_b;
        logic emit_c;
        logic emit_d;
    } sed_flags_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [EV_W-1:0]  edge_level;
        logic             frame_last;
    } sed_result_t;

    typedef struct packed {
        sed_result_t [RES_MAX-1:0] res;
        logic [RES_IDX_W-1:0]      last_idx;
    } sed_entry_t;

    function automatic logic [MAG_W-1:0] sed_mag(
        input win_t       w,
        input logic [1:0] up,
        input logic [1:0] mid,
        input logic [1:0] dn,
        input logic [1:0] lf,
        input logic [1:0] ctr,
        input logic [1:0] rt
    );
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [11:0] ngx;
        logic signed [11:0] ngy;
        logic [MAG_W-1:0]   ax;
        logic [MAG_W-1:0]   ay;
        gx = ($signed({4'b0000, w[up][rt]})  - $signed({4'b0000, w[up][lf]}))
           + (($signed({4'b0000, w[mid][rt]}) - $signed({4'b0000, w[mid][lf]})) <<< 1)
           + ($signed({4'b0000, w[dn][rt]})  - $signed({4'b0000, w[dn][lf]}));
        gy = ($signed({4'b0000, w[dn][lf]})  - $signed({4'b0000, w[up][lf]}))
           + (($signed({4'b0000, w[dn][ctr]}) - $signed({4'b0000, w[up][ctr]})) <<< 1)
           + ($signed({4'b0000, w[dn][rt]})  - $signed({4'b0000, w[up][rt]}));
        ngx = -gx;
        ngy = -gy;
        ax  = gx[11] ? ngx[MAG_W-1:0] : gx[MAG_W-1:0];
        ay  = gy[11] ? ngy[MAG_W-1:0] : gy[MAG_W-1:0];
        return ax + ay;
    endfunction

endpackage

// ===== rtl/sed_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_if: stream and configuration channels of the Sobel edge detector
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface sed_pix_if import sed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sed_res_if import sed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [EV_W-1:0]  edge_level;
    logic             frame_last;

    modport source (output valid, output magnitude, output edge_level,
                    output frame_last, input ready);
    modport sink   (input valid, input magnitude, input edge_level,
                    input frame_last, output ready);
endinterface

interface sed_cfg_if import sed_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sed_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_ram: generic single-write, single-read RAM
// One write port and one registered read port; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module sed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sobel_edge_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_detector: streaming 3x3 Sobel edge detector
// Raster-order grey pixels in, |Gx|+|Gy| magnitude and thresholded edge level
// out, with two line stores and a 3x3 window; border neighbours replicate.
// ----------------------------------------------------------------------------
//   channel | role   | beat carries
//   pix     | sink   | pixel
//   res     | source | magnitude, edge_level, frame_last
//   cfg     | sink   | index, data (always ready)
//
// One pixel beat per cycle while the result side keeps up; a pixel that
// completes k windows yields k result beats on res (k from 0 to 4).
// The first result of a pixel passes the line-store read stage, the window stage and the result queue.
// pix.ready drops when the eight-entry result queue plus the two pixels in
// the line-store read and window stages would leave no free entry.
// Reset restores the registers to defaults and clears counters and window;
// the line stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_detector import sed_pkg::*; #(
    parameter int MAX_WIDTH = SED_MAX_WIDTH
) (
    input logic       clk,
    input logic       rst_n,
    sed_pix_if.sink   pix,
    sed_res_if.source res,
    sed_cfg_if.sink   cfg
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam logic [WCMP_W-1:0] MAX_W_CMP = WCMP_W'(MAX_WIDTH);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [THR_W-1:0] threshold_raw_reg;
    logic [EV_W-1:0]  edge_value_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [FH_W-1:0]  row_reg;
    logic [FH_W-1:0]  row_next;

    logic [WCMP_W-1:0] fw_ext;
    logic [WCMP_W-1:0] wdt_eff;
    logic [WCMP_W-1:0] col_plus1;
    logic [FH_W-1:0]   hgt_eff;
    logic [FH_W:0]     row_plus1;
    logic              eol;
    logic              lastrow;
    logic              in_accept;
    sed_flags_t        flags_new;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    sed_flags_t       s1_flags_reg;
    logic             byp_reg;
    logic [PIX_W-1:0] byp_a_reg;
    logic [PIX_W-1:0] byp_b_reg;
    logic [PIX_W-1:0] line_a_rd;
    logic [PIX_W-1:0] line_b_rd;
    logic [PIX_W-1:0] line_a_eff;
    logic [PIX_W-1:0] line_b_eff;

    win_t win_reg;

    logic        s2_valid_reg;
    sed_flags_t  s2_flags_reg;
    logic [1:0]  up_a;
    logic [1:0]  up_c;
    logic [1:0]  lf_ac;
    logic [1:0]  lf_bd;
    logic [MAG_W-1:0] mag_all [RES_MAX];
    sed_result_t res_all [RES_MAX];
    logic [RES_MAX-1:0] emit_v;
    sed_entry_t  entry_new;
    logic [2:0]  entry_n;
    logic        push;

    sed_entry_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic [RES_IDX_W-1:0]  sub_reg;
    logic [RES_IDX_W-1:0]  sub_next;
    sed_entry_t            head;
    sed_result_t           head_res;
    logic                  out_beat;
    logic                  pop;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            threshold_raw_reg <= THRESHOLD_RST;
            edge_value_reg    <= EDGE_VALUE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg   <= cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg  <= cfg.data[FH_W-1:0];
                REG_THRESHOLD:    threshold_raw_reg <= cfg.data[THR_W-1:0];
                REG_EDGE_VALUE:   edge_value_reg    <= cfg.data[EV_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input position
    // ------------------------------------------------------------------
    assign pix.ready = (cnt_reg + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg))
                       < FIFO_CNT_W'(FIFO_DEPTH);
    assign in_accept = pix.valid && pix.ready;

    always_comb
    begin
        fw_ext    = WCMP_W'(frame_width_reg);
        wdt_eff   = (fw_ext == '0) ? WCMP_W'(1) : ((fw_ext > MAX_W_CMP) ? MAX_W_CMP : fw_ext);
        col_plus1 = WCMP_W'(col_reg) + WCMP_W'(1);
        eol       = (col_plus1 >= wdt_eff);
        hgt_eff   = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
        row_plus1 = {1'b0, row_reg} + (FH_W + 1)'(1);
        lastrow   = (row_plus1 >= {1'b0, hgt_eff});

        col_next = eol ? '0 : col_plus1[COL_W-1:0];
        if (eol)
        begin
            row_next = lastrow ? '0 : row_plus1[FH_W-1:0];
        end
        else
        begin
            row_next = row_reg;
        end

        flags_new.c_eq0  = (col_reg == '0);
        flags_new.c_eq1  = (col_reg == COL_W'(1));
        flags_new.r_eq0  = (row_reg == '0);
        flags_new.r_eq1  = (row_reg == FH_W'(1));
        flags_new.emit_a = !flags_new.r_eq0 && !flags_new.c_eq0;
        flags_new.emit_b = !flags_new.r_eq0 && eol;
        flags_new.emit_c = lastrow && !flags_new.c_eq0;
        flags_new.emit_d = lastrow && eol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // line stores and window
    // ------------------------------------------------------------------
    sed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (line_a_rd)
    );

    sed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_a_eff),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (line_b_rd)
    );

    // forward the column written in the same cycle as the read
    assign line_a_eff = byp_reg ? byp_a_reg : line_a_rd;
    assign line_b_eff = byp_reg ? byp_b_reg : line_b_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            byp_reg      <= in_accept && s1_valid_reg && (s1_col_reg == col_reg);
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][COL_L] <= win_reg[i][COL_C];
                    win_reg[i][COL_C] <= win_reg[i][COL_R];
                end
                win_reg[ROW_UP][COL_R]  <= line_b_eff;
                win_reg[ROW_MID][COL_R] <= line_a_eff;
                win_reg[ROW_DN][COL_R]  <= s1_pixel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pix.pixel;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_new;
        end
        if (s1_valid_reg)
        begin
            byp_a_reg    <= s1_pixel_reg;
            byp_b_reg    <= line_a_eff;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // gradients of up to four completed windows
    // ------------------------------------------------------------------
    always_comb
    begin
        up_a  = s2_flags_reg.r_eq1 ? ROW_MID : ROW_UP;
        up_c  = s2_flags_reg.r_eq0 ? ROW_DN : ROW_MID;
        lf_ac = s2_flags_reg.c_eq1 ? COL_C : COL_L;
        lf_bd = s2_flags_reg.c_eq0 ? COL_R : COL_C;

        mag_all[0] = sed_mag(win_reg, up_a, ROW_MID, ROW_DN, lf_ac, COL_C, COL_R);
        mag_all[1] = sed_mag(win_reg, up_a, ROW_MID, ROW_DN, lf_bd, COL_R, COL_R);
        mag_all[2] = sed_mag(win_reg, up_c, ROW_DN, ROW_DN, lf_ac, COL_C, COL_R);
        mag_all[3] = sed_mag(win_reg, up_c, ROW_DN, ROW_DN, lf_bd, COL_R, COL_R);

        for (int k = 0; k < RES_MAX; k++)
        begin
            res_all[k].magnitude  = mag_all[k];
            res_all[k].edge_level = (mag_all[k] > threshold_raw_reg) ? edge_value_reg : '0;
            res_all[k].frame_last = (k == RES_MAX - 1);
        end

        emit_v = {s2_flags_reg.emit_d, s2_flags_reg.emit_c,
                  s2_flags_reg.emit_b, s2_flags_reg.emit_a};

        // pack in raster order
        entry_new = '0;
        entry_n   = '0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            if (emit_v[k])
            begin
                entry_new.res[entry_n[RES_IDX_W-1:0]] = res_all[k];
                entry_n = entry_n + 3'd1;
            end
        end
        entry_new.last_idx = RES_IDX_W'(entry_n - 3'd1);
        push = s2_valid_reg && (entry_n != '0);
    end

    // ------------------------------------------------------------------
    // result queue, one entry per pixel that completes a window, drained one beat at a time
    // ------------------------------------------------------------------
    assign head     = fifo_mem_reg[rd_ptr_reg];
    assign head_res = head.res[sub_reg];
    assign out_beat = res.valid && res.ready;
    assign pop      = out_beat && (sub_reg == head.last_idx);

    assign res.valid      = (cnt_reg != '0);
    assign res.magnitude  = head_res.magnitude;
    assign res.edge_level = head_res.edge_level;
    assign res.frame_last = head_res.frame_last;

    always_comb
    begin
        cnt_next = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        if (pop)
        begin
            sub_next = '0;
        end
        else if (out_beat)
        begin
            sub_next = sub_reg + RES_IDX_W'(1);
        end
        else
        begin
            sub_next = sub_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sub_reg <= sub_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= entry_new;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg < FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result pushed into a full queue");

    a_sub_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (sub_reg <= head.last_idx))
        else $error("result index past end of entry");

    a_bypass_stage: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_valid_reg)
        else $error("line store forward without a pixel in the read stage");

endmodule
